[rtl/dif_pkg.sv]
package dif_pkg;

  localparam int unsigned NOW_W     = 64;
  localparam int unsigned EXT_W     = 32;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_EXT    = 3'd1,
    ST_CLOCK_FAIL = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXT_SECONDS = 2'd0,
    CFG_EXT_LIMIT   = 2'd1
  } cfg_idx_e;

  typedef logic [3:0] digit_t;

  // Decimal digits of one deadline, plus the outcome of the checks.
  typedef struct packed {
    status_e status;
    digit_t  yr3;
    digit_t  yr2;
    digit_t  yr1;
    digit_t  yr0;
    digit_t  mon1;
    digit_t  mon0;
    digit_t  day1;
    digit_t  day0;
    digit_t  hr1;
    digit_t  hr0;
    digit_t  min1;
    digit_t  min0;
    digit_t  sec1;
    digit_t  sec0;
  } dif_stamp_t;

endpackage

[rtl/dif_in_if.sv]
interface dif_in_if import dif_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NOW_W-1:0] now_seconds;
  logic                    clock_ok;

  modport source (output valid, output now_seconds, output clock_ok, input ready);
  modport sink   (input valid, input now_seconds, input clock_ok, output ready);
endinterface

[rtl/dif_out_if.sv]
interface dif_out_if import dif_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   text_char;
  logic                last_char;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output text_char, output last_char, output status,
                  input ready);
  modport sink   (input valid, input text_char, input last_char, input status,
                  output ready);
endinterface

[rtl/dif_cfg_if.sv]
interface dif_cfg_if import dif_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [EXT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dif_pipe.sv]
module dif_pipe import dif_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [NOW_W-1:0] now_seconds_i,
  input  logic             clock_ok_i,
  input  logic [EXT_W-1:0] ext_seconds_i,
  input  logic [EXT_W-1:0] ext_limit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dif_stamp_t       out_stamp_o
);

  localparam int unsigned NSTG  = 14;
  localparam int unsigned NLANE = 7;

  // two-digit lanes
  localparam int unsigned LN_YHI = 0;
  localparam int unsigned LN_YLO = 1;
  localparam int unsigned LN_MON = 2;
  localparam int unsigned LN_DAY = 3;
  localparam int unsigned LN_HR  = 4;
  localparam int unsigned LN_MIN = 5;
  localparam int unsigned LN_SEC = 6;

  localparam logic [NOW_W-1:0] MAX_DEADLINE  = 64'd253402300799;
  localparam logic [16:0]      SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0]      SECS_PER_HOUR = 12'd3600;
  localparam logic [21:0]      EPOCH_SHIFT   = 22'd719468;
  localparam logic [17:0]      DAYS_PER_ERA  = 18'd146097;

  // floor(x / D) = (x * ceil(2^S / D)) >> S, exact while 2^S >= x_max * D
  localparam int unsigned DAY_SHIFT  = 41;  // (sum >> 7) / 675
  localparam int unsigned HOUR_SHIFT = 29;
  localparam int unsigned MIN_SHIFT  = 18;
  localparam int unsigned ERA_SHIFT  = 40;
  localparam int unsigned A_SHIFT    = 29;
  localparam int unsigned YOE_SHIFT  = 27;
  localparam int unsigned MP_SHIFT   = 20;
  localparam int unsigned HI_SHIFT   = 21;
  localparam int unsigned TEN_SHIFT  = 11;

  localparam logic [31:0] DAY_MUL  = 32'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
  localparam logic [17:0] HOUR_MUL = 18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_MUL  = 13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
  localparam logic [22:0] ERA_MUL  = 23'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);
  localparam logic [18:0] A_MUL    = 19'(((64'd1 << A_SHIFT) + 64'd1459) / 64'd1460);
  localparam logic [18:0] YOE_MUL  = 19'(((64'd1 << YOE_SHIFT) + 64'd364) / 64'd365);
  localparam logic [12:0] MP_MUL   = 13'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);
  localparam logic [14:0] HI_MUL   = 15'(((64'd1 << HI_SHIFT) + 64'd99) / 64'd100);
  localparam logic [7:0]  TEN_MUL  = 8'(((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10);

  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'(TEN_MUL);
    return p[TEN_SHIFT +: 4];
  endfunction

  // first day of shifted month mp (March based), (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    case (mp)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  logic            en;
  logic [NSTG-1:0] v_q;
  status_e         st_q [NSTG-1];  // stages 2 .. NSTG

  // stage 1
  logic [63:0] s1_sum_q;
  logic        s1_ext_bad_q, s1_clk_bad_q, s1_neg_q;
  // stage 2
  status_e     st_d;
  logic [37:0] s2_sum_q;
  logic [62:0] s2_dprod_q, s2_dprod_d;
  // stage 3
  logic [21:0] days;
  logic [37:0] dsec;
  logic [21:0] s3_z_q, s3_z_d;
  logic [16:0] s3_rem_q, s3_rem_d;
  // stage 4
  logic [44:0] s4_eprod_q, s4_eprod_d;
  logic [34:0] s4_hprod_q, s4_hprod_d;
  logic [21:0] s4_z_q;
  logic [16:0] s4_rem_q;
  // stage 5
  logic [4:0]  era, hr;
  logic [4:0]  s5_era_q, s5_hr_q;
  logic [17:0] s5_doe_q, s5_doe_d;
  logic [11:0] s5_rh_q, s5_rh_d;
  // stage 6
  logic [36:0] s6_aprod_q, s6_aprod_d;
  logic [24:0] s6_mprod_q, s6_mprod_d;
  logic [2:0]  s6_b_q, s6_b_d;
  logic        s6_c_q, s6_c_d;
  logic [17:0] s6_doe_q;
  logic [11:0] s6_rh_q;
  logic [4:0]  s6_era_q, s6_hr_q;
  // stage 7
  logic [6:0]  a_q7;
  logic [17:0] t7;
  logic [5:0]  min7;
  logic [36:0] s7_yprod_q, s7_yprod_d;
  logic [17:0] s7_doe_q;
  logic [4:0]  s7_era_q, s7_hr_q;
  logic [5:0]  s7_min_q, s7_sec_q, s7_sec_d;
  // stage 8
  logic [8:0]  yoe;
  logic [1:0]  yoe_c;
  logic [17:0] yday;
  logic [8:0]  s8_doy_q, s8_doy_d, s8_yoe_q;
  logic [4:0]  s8_era_q, s8_hr_q;
  logic [5:0]  s8_min_q, s8_sec_q;
  // stage 9
  logic [11:0] mpx;
  logic [24:0] s9_mpprod_q, s9_mpprod_d;
  logic [8:0]  s9_doy_q, s9_yoe_q;
  logic [4:0]  s9_era_q, s9_hr_q;
  logic [5:0]  s9_min_q, s9_sec_q;
  // stage 10
  logic [3:0]  mp;
  logic [13:0] s10_yr_q, s10_yr_d;
  logic [3:0]  s10_mon_q, s10_mon_d;
  logic [4:0]  s10_day_q, s10_day_d;
  logic [4:0]  s10_hr_q;
  logic [5:0]  s10_min_q, s10_sec_q;
  // stage 11
  logic [28:0] s11_hiprod_q, s11_hiprod_d;
  logic [13:0] s11_yr_q;
  logic [3:0]  s11_mon_q;
  logic [4:0]  s11_day_q, s11_hr_q;
  logic [5:0]  s11_min_q, s11_sec_q;
  // stages 12 .. 14, two-digit lanes
  logic [6:0]  yhi;
  logic [6:0]  s12_val_q [NLANE];
  logic [6:0]  s12_val_d [NLANE];
  logic [6:0]  s13_val_q [NLANE];
  digit_t      s13_ten_q [NLANE];
  digit_t      s14_ten_q [NLANE];
  digit_t      s14_one_q [NLANE];

  assign en          = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];

  always_comb begin
    // stage 2: checks in priority order
    if (s1_ext_bad_q) begin
      st_d = ST_BAD_EXT;
    end else if (s1_clk_bad_q) begin
      st_d = ST_CLOCK_FAIL;
    end else if (s1_neg_q || s1_sum_q[63]) begin
      st_d = ST_OVERFLOW;
    end else if (s1_sum_q > MAX_DEADLINE) begin
      st_d = ST_RANGE;
    end else begin
      st_d = ST_OK;
    end
    s2_dprod_d = 63'(s1_sum_q[37:7]) * 63'(DAY_MUL);

    // stage 3: day count and second of day
    days     = s2_dprod_q[DAY_SHIFT +: 22];
    dsec     = 38'(days) * 38'(SECS_PER_DAY);
    s3_rem_d = 17'(s2_sum_q - dsec);
    s3_z_d   = days + EPOCH_SHIFT;

    // stage 4
    s4_eprod_d = 45'(s3_z_q) * 45'(ERA_MUL);
    s4_hprod_d = 35'(s3_rem_q) * 35'(HOUR_MUL);

    // stage 5: era, day of era, hour
    era      = s4_eprod_q[ERA_SHIFT +: 5];
    s5_doe_d = 18'(s4_z_q - 22'(era) * 22'(DAYS_PER_ERA));
    hr       = s4_hprod_q[HOUR_SHIFT +: 5];
    s5_rh_d  = 12'(s4_rem_q - 17'(hr) * 17'(SECS_PER_HOUR));

    // stage 6: leap corrections; doe / 36524 and doe / 146096 by compare
    s6_aprod_d = 37'(s5_doe_q) * 37'(A_MUL);
    s6_b_d     = 3'(s5_doe_q >= 18'd36524) + 3'(s5_doe_q >= 18'd73048)
               + 3'(s5_doe_q >= 18'd109572) + 3'(s5_doe_q >= 18'd146096);
    s6_c_d     = (s5_doe_q == 18'd146096);
    s6_mprod_d = 25'(s5_rh_q) * 25'(MIN_MUL);

    // stage 7: year of era product, minute and second
    a_q7       = s6_aprod_q[A_SHIFT +: 7];
    t7         = s6_doe_q - 18'(a_q7) + 18'(s6_b_q) - 18'(s6_c_q);
    s7_yprod_d = 37'(t7) * 37'(YOE_MUL);
    min7       = s6_mprod_q[MIN_SHIFT +: 6];
    s7_sec_d   = 6'(s6_rh_q - 12'(min7) * 12'd60);

    // stage 8: day of year
    yoe      = s7_yprod_q[YOE_SHIFT +: 9];
    yoe_c    = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    yday     = 18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(yoe_c);
    s8_doy_d = 9'(s7_doe_q - yday);

    // stage 9
    mpx         = 12'(12'(s8_doy_q) * 12'd5 + 12'd2);
    s9_mpprod_d = 25'(mpx) * 25'(MP_MUL);

    // stage 10: month, day, year
    mp        = s9_mpprod_q[MP_SHIFT +: 4];
    s10_mon_d = (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
    s10_day_d = 5'(s9_doy_q - month_start(mp) + 9'd1);
    s10_yr_d  = 14'(14'(s9_yoe_q) + 14'(s9_era_q) * 14'd400 + 14'(s10_mon_d <= 4'd2));

    // stage 11
    s11_hiprod_d = 29'(s10_yr_q) * 29'(HI_MUL);

    // stage 12: year split into centuries and the rest
    yhi                = s11_hiprod_q[HI_SHIFT +: 7];
    s12_val_d[LN_YHI] = yhi;
    s12_val_d[LN_YLO] = 7'(s11_yr_q - 14'(yhi) * 14'd100);
    s12_val_d[LN_MON] = 7'(s11_mon_q);
    s12_val_d[LN_DAY] = 7'(s11_day_q);
    s12_val_d[LN_HR]  = 7'(s11_hr_q);
    s12_val_d[LN_MIN] = 7'(s11_min_q);
    s12_val_d[LN_SEC] = 7'(s11_sec_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q     <= now_seconds_i + 64'(ext_seconds_i);
      s1_ext_bad_q <= (ext_seconds_i == '0) || (ext_seconds_i > ext_limit_i);
      s1_clk_bad_q <= !clock_ok_i;
      s1_neg_q     <= now_seconds_i[NOW_W-1];

      st_q[0] <= st_d;
      for (int i = 1; i < NSTG - 1; i++) begin
        st_q[i] <= st_q[i-1];
      end

      s2_sum_q   <= s1_sum_q[37:0];
      s2_dprod_q <= s2_dprod_d;

      s3_z_q   <= s3_z_d;
      s3_rem_q <= s3_rem_d;

      s4_eprod_q <= s4_eprod_d;
      s4_hprod_q <= s4_hprod_d;
      s4_z_q     <= s3_z_q;
      s4_rem_q   <= s3_rem_q;

      s5_era_q <= era;
      s5_doe_q <= s5_doe_d;
      s5_hr_q  <= hr;
      s5_rh_q  <= s5_rh_d;

      s6_aprod_q <= s6_aprod_d;
      s6_mprod_q <= s6_mprod_d;
      s6_b_q     <= s6_b_d;
      s6_c_q     <= s6_c_d;
      s6_doe_q   <= s5_doe_q;
      s6_rh_q    <= s5_rh_q;
      s6_era_q   <= s5_era_q;
      s6_hr_q    <= s5_hr_q;

      s7_yprod_q <= s7_yprod_d;
      s7_doe_q   <= s6_doe_q;
      s7_era_q   <= s6_era_q;
      s7_hr_q    <= s6_hr_q;
      s7_min_q   <= min7;
      s7_sec_q   <= s7_sec_d;

      s8_doy_q <= s8_doy_d;
      s8_yoe_q <= yoe;
      s8_era_q <= s7_era_q;
      s8_hr_q  <= s7_hr_q;
      s8_min_q <= s7_min_q;
      s8_sec_q <= s7_sec_q;

      s9_mpprod_q <= s9_mpprod_d;
      s9_doy_q    <= s8_doy_q;
      s9_yoe_q    <= s8_yoe_q;
      s9_era_q    <= s8_era_q;
      s9_hr_q     <= s8_hr_q;
      s9_min_q    <= s8_min_q;
      s9_sec_q    <= s8_sec_q;

      s10_yr_q  <= s10_yr_d;
      s10_mon_q <= s10_mon_d;
      s10_day_q <= s10_day_d;
      s10_hr_q  <= s9_hr_q;
      s10_min_q <= s9_min_q;
      s10_sec_q <= s9_sec_q;

      s11_hiprod_q <= s11_hiprod_d;
      s11_yr_q     <= s10_yr_q;
      s11_mon_q    <= s10_mon_q;
      s11_day_q    <= s10_day_q;
      s11_hr_q     <= s10_hr_q;
      s11_min_q    <= s10_min_q;
      s11_sec_q    <= s10_sec_q;

      for (int l = 0; l < NLANE; l++) begin
        s12_val_q[l] <= s12_val_d[l];
        s13_val_q[l] <= s12_val_q[l];
        s13_ten_q[l] <= div10(s12_val_q[l]);
        s14_ten_q[l] <= s13_ten_q[l];
        s14_one_q[l] <= 4'(s13_val_q[l] - 7'(s13_ten_q[l]) * 7'd10);
      end
    end
  end

  always_comb begin
    out_stamp_o.status = st_q[NSTG-2];
    out_stamp_o.yr3    = s14_ten_q[LN_YHI];
    out_stamp_o.yr2    = s14_one_q[LN_YHI];
    out_stamp_o.yr1    = s14_ten_q[LN_YLO];
    out_stamp_o.yr0    = s14_one_q[LN_YLO];
    out_stamp_o.mon1   = s14_ten_q[LN_MON];
    out_stamp_o.mon0   = s14_one_q[LN_MON];
    out_stamp_o.day1   = s14_ten_q[LN_DAY];
    out_stamp_o.day0   = s14_one_q[LN_DAY];
    out_stamp_o.hr1    = s14_ten_q[LN_HR];
    out_stamp_o.hr0    = s14_one_q[LN_HR];
    out_stamp_o.min1   = s14_ten_q[LN_MIN];
    out_stamp_o.min0   = s14_one_q[LN_MIN];
    out_stamp_o.sec1   = s14_ten_q[LN_SEC];
    out_stamp_o.sec0   = s14_one_q[LN_SEC];
  end

endmodule

[rtl/deadline_iso8601_formatter.sv]
// Channel  Dir  Payload                               Beat
// in_if    in   now_seconds[63:0] signed, clock_ok    one per deadline request
// cfg_if   in   index[1:0], data[31:0]                one register write
// out_if   out  text_char[6:0], last_char, status[2:0] one character or one error
//
// A request passes a 14-stage date pipeline and then a character serializer.
// First character shows once the request has left the pipeline and been loaded into
// the serializer; a good deadline gives 20 beats, one per cycle while out_if is ready,
// an error gives one beat. Good requests are paced by the serializer, which takes a new
// stamp only on the last beat of the one it holds; rejected ones go one per cycle then.
// Reset clears all valid bits, the extension register to 0, the limit to all ones.
// Back-pressure on out_if stalls the pipeline only once its last stage is full.
module deadline_iso8601_formatter import dif_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  dif_cfg_if.sink   cfg_if,
  dif_in_if.sink    in_if,
  dif_out_if.source out_if
);

  localparam logic [4:0]        LAST_POS = 5'd19;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_T     = 7'h54;
  localparam logic [CHAR_W-1:0] CH_Z     = 7'h5A;

  function automatic logic [CHAR_W-1:0] dchar(input digit_t d);
    return 7'(CH_ZERO + 7'(d));
  endfunction

  logic [EXT_W-1:0] ext_q, lim_q;

  logic        pipe_v, pipe_ready, pipe_take;
  dif_stamp_t  pipe_stamp;

  logic        ser_v_q;
  logic [4:0]  ser_cnt_q;
  dif_stamp_t  ser_q;
  logic        ser_last, beat;
  logic [CHAR_W-1:0] ch;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= '0;
      lim_q <= '1;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_EXT_SECONDS: ext_q <= cfg_if.data;
        CFG_EXT_LIMIT:   lim_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  dif_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_o    (in_if.ready),
    .now_seconds_i (in_if.now_seconds),
    .clock_ok_i    (in_if.clock_ok),
    .ext_seconds_i (ext_q),
    .ext_limit_i   (lim_q),
    .out_valid_o   (pipe_v),
    .out_ready_i   (pipe_ready),
    .out_stamp_o   (pipe_stamp)
  );

  // serializer: holds one stamp, walks its 20 characters, or gives one beat for an error
  assign ser_last   = (ser_q.status != ST_OK) || (ser_cnt_q == LAST_POS);
  assign beat       = ser_v_q && out_if.ready;
  assign pipe_ready = !ser_v_q || (beat && ser_last);
  assign pipe_take  = pipe_v && pipe_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_cnt_q <= '0;
    end else if (pipe_take) begin
      ser_v_q   <= 1'b1;
      ser_cnt_q <= '0;
    end else if (beat && ser_last) begin
      ser_v_q <= 1'b0;
    end else if (beat) begin
      ser_cnt_q <= ser_cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_take) begin
      ser_q <= pipe_stamp;
    end
  end

  always_comb begin
    case (ser_cnt_q)
      5'd0:    ch = dchar(ser_q.yr3);
      5'd1:    ch = dchar(ser_q.yr2);
      5'd2:    ch = dchar(ser_q.yr1);
      5'd3:    ch = dchar(ser_q.yr0);
      5'd4:    ch = CH_DASH;
      5'd5:    ch = dchar(ser_q.mon1);
      5'd6:    ch = dchar(ser_q.mon0);
      5'd7:    ch = CH_DASH;
      5'd8:    ch = dchar(ser_q.day1);
      5'd9:    ch = dchar(ser_q.day0);
      5'd10:   ch = CH_T;
      5'd11:   ch = dchar(ser_q.hr1);
      5'd12:   ch = dchar(ser_q.hr0);
      5'd13:   ch = CH_COLON;
      5'd14:   ch = dchar(ser_q.min1);
      5'd15:   ch = dchar(ser_q.min0);
      5'd16:   ch = CH_COLON;
      5'd17:   ch = dchar(ser_q.sec1);
      5'd18:   ch = dchar(ser_q.sec0);
      5'd19:   ch = CH_Z;
      default: ch = '0;
    endcase
  end

  assign out_if.valid     = ser_v_q;
  assign out_if.text_char = (ser_q.status == ST_OK) ? ch : '0;
  assign out_if.last_char = ser_last;
  assign out_if.status    = ser_q.status;

  a_ser_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_v_q && out_if.ready && !ser_last
    |=> ser_v_q && (ser_cnt_q == $past(ser_cnt_q) + 5'd1))
    else $error("serializer skipped or repeated a character");

  a_ser_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_take |=> ser_v_q && (ser_cnt_q == '0))
    else $error("stamp loaded without restarting at the first character");

  a_ser_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.last_char && !pipe_v |=> !out_if.valid)
    else $error("output still valid after final beat with nothing pending");

  a_cfg_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_if.valid && (cfg_if.index == CFG_EXT_LIMIT) |=> lim_q == $past(cfg_if.data))
    else $error("limit write lost");

endmodule

[test/deadline_iso8601_formatter_tb.sv]
`timescale 1ns / 100ps

module deadline_iso8601_formatter_tb;
  import dif_pkg::*;

  localparam logic [63:0] MAX_DEADLINE = 64'd253402300799;
  localparam logic [63:0] SIGNED_TOP   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DAY_SECS     = 64'd86400;
  localparam logic [63:0] LAST_DAY     = 64'd2932896;  // 9999-12-31 as a day count
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;
  localparam logic [EXT_W-1:0] EXT_ALL = 32'hFFFF_FFFF;
  localparam byte CH_ZERO  = "0";
  localparam byte CH_DASH  = "-";
  localparam byte CH_TEE   = "T";
  localparam byte CH_COLON = ":";
  localparam byte CH_ZULU  = "Z";
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    status_e           st;
  } char_beat_t;

  class deadline_scoreboard;
    char_beat_t       text_q[$];
    logic [EXT_W-1:0] ext_secs;
    logic [EXT_W-1:0] ext_limit;
    int unsigned      n_err;
    int unsigned      n_req;
    int unsigned      n_dated;
    int unsigned      n_beats;

    function new();
      ext_secs  = '0;
      ext_limit = '1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
      if (idx == CFG_EXT_SECONDS) ext_secs = val;
      else if (idx == CFG_EXT_LIMIT) ext_limit = val;
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      n_err++;
    endtask

    function logic [CHAR_W-1:0] digit(logic [63:0] v);
      logic [7:0] c;
      c = CH_ZERO + 8'(v % 64'd10);
      return c[CHAR_W-1:0];
    endfunction

    function void push_error(status_e st);
      char_beat_t b;
      b.ch   = '0;
      b.last = 1'b1;
      b.st   = st;
      text_q.push_back(b);
    endfunction

    // Works out the text of the deadline now + extension, or the error beat.
    function void note_request(logic [63:0] now, logic ok);
      logic [63:0] sum, days, tod, z, era, doe, yoe, doy, mp, mon, dom, yr;
      logic [CHAR_W-1:0] txt [20];
      char_beat_t b;
      n_req++;
      if (ext_secs == '0 || ext_secs > ext_limit) begin
        push_error(ST_BAD_EXT);
        return;
      end
      if (!ok) begin
        push_error(ST_CLOCK_FAIL);
        return;
      end
      if (now[63]) begin
        push_error(ST_OVERFLOW);
        return;
      end
      sum = now + {32'd0, ext_secs};
      if (sum[63]) begin
        push_error(ST_OVERFLOW);
        return;
      end
      if (sum > MAX_DEADLINE) begin
        push_error(ST_RANGE);
        return;
      end
      days = sum / DAY_SECS;
      tod  = sum % DAY_SECS;
      // civil date from days, counting from 0000-03-01 in 400-year eras
      z   = days + 64'd719468;
      era = z / 64'd146097;
      doe = z - era * 64'd146097;
      yoe = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
      doy = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
      mp  = (64'd5 * doy + 64'd2) / 64'd153;
      mon = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
      dom = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
      yr  = yoe + era * 64'd400 + ((mon <= 64'd2) ? 64'd1 : 64'd0);
      txt[0]  = digit(yr / 64'd1000);
      txt[1]  = digit(yr / 64'd100);
      txt[2]  = digit(yr / 64'd10);
      txt[3]  = digit(yr);
      txt[4]  = CH_DASH[CHAR_W-1:0];
      txt[5]  = digit(mon / 64'd10);
      txt[6]  = digit(mon);
      txt[7]  = CH_DASH[CHAR_W-1:0];
      txt[8]  = digit(dom / 64'd10);
      txt[9]  = digit(dom);
      txt[10] = CH_TEE[CHAR_W-1:0];
      txt[11] = digit(tod / 64'd36000);
      txt[12] = digit(tod / 64'd3600);
      txt[13] = CH_COLON[CHAR_W-1:0];
      txt[14] = digit((tod % 64'd3600) / 64'd600);
      txt[15] = digit((tod % 64'd3600) / 64'd60);
      txt[16] = CH_COLON[CHAR_W-1:0];
      txt[17] = digit((tod % 64'd60) / 64'd10);
      txt[18] = digit(tod % 64'd60);
      txt[19] = CH_ZULU[CHAR_W-1:0];
      for (int k = 0; k < 20; k++) begin
        b.ch   = txt[k];
        b.last = (k == 19);
        b.st   = ST_OK;
        text_q.push_back(b);
      end
      n_dated++;
    endfunction

    task check_beat(logic [CHAR_W-1:0] ch, logic last, logic [STATUS_W-1:0] st);
      char_beat_t w;
      n_beats++;
      if (text_q.size() == 0) begin
        report($sformatf("beat with nothing pending: char %h last %b status %0d",
                         ch, last, st));
        return;
      end
      w = text_q.pop_front();
      if (ch !== w.ch || last !== w.last || st !== w.st)
        report($sformatf("char %h/%h last %b/%b status %0d/%0d (got/want)",
                         ch, w.ch, last, w.last, st, w.st));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int unsigned cycles;
  int unsigned n_writes;
  deadline_scoreboard sb;

  dif_cfg_if cfg_if ();
  dif_in_if  in_if ();
  dif_out_if out_if ();

  deadline_iso8601_formatter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_beat(out_if.text_char, out_if.last_char, out_if.status);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles, sb.pending());
      $display("deadline_iso8601_formatter_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(logic [63:0] now, logic ok);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.now_seconds <= now;
    in_if.clock_ok    <= ok;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(now, ok);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    n_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic hold_for_drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_for_drain();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_now(logic [EXT_W-1:0] ext);
    logic [63:0] span, v, days, tod;
    int r;
    r    = $urandom_range(0, 99);
    span = MAX_DEADLINE - {32'd0, ext};
    if (r < 55) begin
      v = {$urandom, $urandom} % (span + 64'd1);
    end else if (r < 70) begin
      // land right on a midnight, one second short of it, or at a random time of that day
      days = $urandom_range(0, LAST_DAY);
      case ($urandom_range(0, 2))
        0:       tod = 64'd0;
        1:       tod = DAY_SECS - 64'd1;
        default: tod = $urandom_range(0, 86399);
      endcase
      v = days * DAY_SECS + tod;
      if (v >= {32'd0, ext}) v = v - {32'd0, ext};
    end else if (r < 78) begin
      v = span + $urandom_range(0, 6) - 64'd3;
    end else if (r < 84) begin
      v = SIGNED_TOP - {32'd0, ext} + $urandom_range(0, 6) - 64'd3;
    end else if (r < 92) begin
      v = {$urandom, $urandom};
    end else begin
      v = $urandom_range(0, 200);
    end
    return v;
  endfunction

  task automatic run_phase(int n, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) hold_for_drain();
      send_request(pick_now(sb.ext_secs), $urandom_range(0, 99) >= 7);
    end
    settle();
  endtask

  initial begin
    logic [EXT_W-1:0] lim;
    sb               = new();
    rst_ni           = 1'b0;
    steady           = 1'b0;
    n_writes         = 0;
    in_if.valid      = 1'b0;
    in_if.now_seconds = '0;
    in_if.clock_ok   = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_EXT_SECONDS;
    cfg_if.data      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extension still at its reset value of zero
    send_request(64'd1000, 1'b1);
    settle();
    write_reg(CFG_EXT_SECONDS, 32'd1);
    send_request(64'd0, 1'b1);
    send_request(MAX_DEADLINE - 64'd1, 1'b1);
    send_request(MAX_DEADLINE, 1'b1);
    send_request(SIGNED_TOP, 1'b1);
    send_request(SIGNED_TOP - 64'd1, 1'b1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(64'h8000_0000_0000_0000, 1'b1);
    send_request(64'd0, 1'b0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // clock failure wins over sign
    send_request(64'd951782399, 1'b1);
    send_request(64'd4107542399, 1'b1);
    send_request(64'd68169599, 1'b1);
    send_request(64'd2147483647, 1'b1);
    settle();
    write_reg(CFG_EXT_SECONDS, EXT_ALL);
    send_request(64'd0, 1'b1);
    send_request(MAX_DEADLINE - {32'd0, EXT_ALL}, 1'b1);
    settle();
    write_reg(CFG_EXT_LIMIT, EXT_ALL - 32'd1);
    send_request(64'd0, 1'b0);  // bad extension is reported before the clock
    settle();
    write_reg(CFG_EXT_LIMIT, 32'd0);
    send_request(64'd5, 1'b1);
    settle();
    write_reg(CFG_EXT_SECONDS, 32'd0);
    write_reg(CFG_EXT_LIMIT, EXT_ALL);
    send_request(64'd5, 1'b1);
    settle();
    write_reg(CFG_EXT_SECONDS, 32'd7);
    write_reg(CFG_EXT_LIMIT, 32'd7);
    write_reg(IDX_SPARE_LO, 32'd0);
    write_reg(IDX_SPARE_HI, 32'd0);
    send_request(64'd0, 1'b1);
    settle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin
          write_reg(CFG_EXT_SECONDS, 32'd1);
          write_reg(CFG_EXT_LIMIT, EXT_ALL);
        end
        1: begin
          write_reg(CFG_EXT_SECONDS, EXT_ALL);
        end
        2: begin
          lim = $urandom_range(1, EXT_ALL);
          write_reg(CFG_EXT_LIMIT, lim);
          write_reg(CFG_EXT_SECONDS, lim);
        end
        3: begin
          lim = $urandom_range(2, EXT_ALL);
          write_reg(CFG_EXT_LIMIT, lim);
          write_reg(CFG_EXT_SECONDS, $urandom_range(1, lim - 32'd1));
        end
        4: begin
          write_reg(CFG_EXT_LIMIT, $urandom_range(1, 1000));
          write_reg(CFG_EXT_SECONDS, $urandom_range(1001, EXT_ALL));
        end
        5: begin
          write_reg(CFG_EXT_LIMIT, EXT_ALL);
          write_reg(CFG_EXT_SECONDS, $urandom_range(1, 86400));
        end
        6: begin
          write_reg(CFG_EXT_LIMIT, $urandom);
          write_reg(CFG_EXT_SECONDS, $urandom);
        end
        default: begin
          write_reg(CFG_EXT_LIMIT, EXT_ALL);
          write_reg(CFG_EXT_SECONDS, $urandom_range(1, EXT_ALL));
        end
      endcase
      steady = (p == 5);
      run_phase((p == 4) ? 12 : 48, p == 3 || p == 7);
      steady = 1'b0;
    end

    settle();
    $display("covered %0d requests (%0d formatted, %0d rejected), %0d beats checked",
             sb.n_req, sb.n_dated, sb.n_req - sb.n_dated, sb.n_beats);
    $display("%0d register writes across reset, extreme and random settings, %0d mismatches",
             n_writes, sb.n_err);
    if (sb.n_err == 0)
      $display("deadline_iso8601_formatter_tb: done, clean");
    else
      $display("deadline_iso8601_formatter_tb: done, errors");
    $finish;
  end

endmodule
